// ----- design/fixed_point_mul_div_16_16_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the 16.16 multiply / divide unit
// Shared forms for same-cycle and next-cycle checks, reset-qualified.
// ---------------------------------------------------------------------------
`ifndef FIXED_POINT_MUL_DIV_16_16_ASSERT_SVH
`define FIXED_POINT_MUL_DIV_16_16_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define FPMD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpmd check failed");

// antecedent implies consequent in the next cycle
`define FPMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fpmd check failed");

`endif

// ----- design/fpmd_pkg.sv -----
// ---------------------------------------------------------------------------
// fpmd_pkg
// Types and constants of the 16.16 fixed-point multiply / divide unit.
// ---------------------------------------------------------------------------
package fpmd_pkg;

   localparam int OP_W      = 32;
   localparam int FRAC_BITS = 16;
   localparam int DVD_W     = OP_W + FRAC_BITS;
   localparam int NUM_CELLS = DVD_W;
   localparam int LATENCY   = NUM_CELLS + 2;

   localparam logic KIND_MUL = 1'b0;
   localparam logic KIND_DIV = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_DIV_ZERO = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic               kind;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic              kind;
      logic              neg;
      logic              bzero;
      logic [DVD_W-1:0]  dvd;
      logic [DVD_W-1:0]  quo;
      logic [OP_W-1:0]   rem;
      logic [OP_W-1:0]   dvs;
      logic [OP_W-1:0]   mul_res;
      logic              mul_ovf;
   } stage_type;

endpackage

// ----- design/fpmd_front.sv -----
// ---------------------------------------------------------------------------
// fpmd_front
// Entry stage: forms the multiply result and the divide magnitudes.
// ---------------------------------------------------------------------------
module fpmd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  fpmd_pkg::req_type   in_req,
   output logic                out_valid,
   output fpmd_pkg::stage_type out_stage
);

   logic signed [31:0]  sa;
   logic signed [31:0]  sb;
   logic signed [63:0]  prod;
   logic [31:0]         ua;
   logic [31:0]         ub;
   logic [31:0]         abs_a;
   logic [31:0]         abs_b;
   logic                valid_ff;
   fpmd_pkg::stage_type stage_ff;
   fpmd_pkg::stage_type stage_in;

   assign sa    = in_req.operand_a;
   assign sb    = in_req.operand_b;
   assign prod  = sa * sb;
   assign ua    = in_req.operand_a;
   assign ub    = in_req.operand_b;
   assign abs_a = ua[31] ? (~ua + 32'd1) : ua;
   assign abs_b = ub[31] ? (~ub + 32'd1) : ub;

   always_comb begin
      stage_in         = '0;
      stage_in.kind    = in_req.kind;
      stage_in.neg     = ua[31] ^ ub[31];
      stage_in.bzero   = (ub == 32'd0);
      stage_in.dvd     = {abs_a, {fpmd_pkg::FRAC_BITS{1'b0}}};
      stage_in.quo     = '0;
      stage_in.rem     = '0;
      stage_in.dvs     = abs_b;
      stage_in.mul_res = prod[47:16];
      stage_in.mul_ovf = !((&prod[63:47]) || !(|prod[63:47]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

// ----- design/fpmd_cell.sv -----
// ---------------------------------------------------------------------------
// fpmd_cell
// One restoring-division step: develops one quotient bit per item.
// ---------------------------------------------------------------------------
module fpmd_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  fpmd_pkg::stage_type in_stage,
   output logic                out_valid,
   output fpmd_pkg::stage_type out_stage
);

   logic [fpmd_pkg::OP_W:0] shifted;
   logic [fpmd_pkg::OP_W:0] diff;
   logic                    ge;
   logic                    valid_ff;
   fpmd_pkg::stage_type     stage_ff;
   fpmd_pkg::stage_type     stage_in;

   assign shifted = {in_stage.rem, in_stage.dvd[fpmd_pkg::DVD_W-1]};
   assign diff    = shifted - {1'b0, in_stage.dvs};
   assign ge      = (shifted >= {1'b0, in_stage.dvs});

   always_comb begin
      stage_in     = in_stage;
      stage_in.dvd = {in_stage.dvd[fpmd_pkg::DVD_W-2:0], 1'b0};
      stage_in.quo = {in_stage.quo[fpmd_pkg::DVD_W-2:0], ge};
      stage_in.rem = ge ? diff[fpmd_pkg::OP_W-1:0] : shifted[fpmd_pkg::OP_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

// ----- design/fpmd_back.sv -----
// ---------------------------------------------------------------------------
// fpmd_back
// Exit stage: applies the quotient sign, range check and status.
// ---------------------------------------------------------------------------
module fpmd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  fpmd_pkg::stage_type in_stage,
   output logic                out_valid,
   output fpmd_pkg::rsp_type   out_rsp
);

   logic [fpmd_pkg::DVD_W-1:0] q;
   logic [fpmd_pkg::DVD_W-1:0] q_signed;
   logic                       q_fits;
   logic                       valid_ff;
   fpmd_pkg::rsp_type          rsp_ff;
   fpmd_pkg::rsp_type          rsp_in;

   assign q        = in_stage.quo;
   assign q_signed = in_stage.neg ? (~q + 1'b1) : q;
   assign q_fits   = (q[fpmd_pkg::DVD_W-1:32] == '0)
                     && (!q[31] || (in_stage.neg && (q[30:0] == 31'd0)));

   always_comb begin
      rsp_in = '0;
      if (in_stage.kind == fpmd_pkg::KIND_MUL) begin
         rsp_in.result_value = in_stage.mul_res;
         rsp_in.status       = in_stage.mul_ovf ? fpmd_pkg::STATUS_OVERFLOW
                                                : fpmd_pkg::STATUS_OK;
      end else if (in_stage.bzero) begin
         rsp_in.result_value = '0;
         rsp_in.status       = fpmd_pkg::STATUS_DIV_ZERO;
      end else begin
         rsp_in.result_value = q_signed[31:0];
         rsp_in.status       = q_fits ? fpmd_pkg::STATUS_OK : fpmd_pkg::STATUS_OVERFLOW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

// ----- design/fixed_point_mul_div_16_16.sv -----
// ---------------------------------------------------------------------------
// fixed_point_mul_div_16_16
// Signed 16.16 multiply / divide, pipelined through a row of divide cells.
//
//   channel   ports                       direction
//   request   start, busy, req_data       in
//   response  rsp_valid, rsp_data         out
//
// One item enters per cycle while busy is low; each result passes
// through one entry stage with the 32x32 multiplier, 48 division cells
// (one quotient bit each) and one exit stage. Multiply items travel the
// same row so results leave in order. busy is high only during reset,
// which empties the row. rsp_valid strobes for one cycle per item and
// the receiver cannot stall it.
// ---------------------------------------------------------------------------
`include "fixed_point_mul_div_16_16_assert.svh"

module fixed_point_mul_div_16_16 (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fpmd_pkg::req_type req_data,
   output logic              rsp_valid,
   output fpmd_pkg::rsp_type rsp_data
);

   logic                in_accept;
   logic                link_valid [fpmd_pkg::NUM_CELLS+1];
   fpmd_pkg::stage_type link_stage [fpmd_pkg::NUM_CELLS+1];

   assign busy      = reset;
   assign in_accept = start && !busy;

   fpmd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_accept),
      .in_req    (req_data),
      .out_valid (link_valid[0]),
      .out_stage (link_stage[0])
   );

   for (genvar i = 0; i < fpmd_pkg::NUM_CELLS; i++) begin : g_cell
      fpmd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[i]),
         .in_stage  (link_stage[i]),
         .out_valid (link_valid[i+1]),
         .out_stage (link_stage[i+1])
      );
   end

   fpmd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (link_valid[fpmd_pkg::NUM_CELLS]),
      .in_stage  (link_stage[fpmd_pkg::NUM_CELLS]),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

   `FPMD_ASSERT_SAME(a_rsp_from_item, clock, reset, rsp_valid,
      $past(in_accept, fpmd_pkg::LATENCY))
   `FPMD_ASSERT_SAME(a_status_code, clock, reset, rsp_valid,
      rsp_data.status <= fpmd_pkg::STATUS_OVERFLOW)
   `FPMD_ASSERT_SAME(a_div_zero_value, clock, reset,
      rsp_valid && (rsp_data.status == fpmd_pkg::STATUS_DIV_ZERO),
      rsp_data.result_value == 32'sd0)
   `FPMD_ASSERT_NEXT(a_front_tracks, clock, reset, in_accept, link_valid[0])

endmodule

// ----- tb/fixed_point_mul_div_16_16_tb.sv -----
// ---------------------------------------------------------------------------
// fixed_point_mul_div_16_16_tb
// Self-checking bench for the signed 16.16 multiply / divide unit. A queue of
// pending items feeds a driver at the falling edge. Each taken item is scored
// against a local model of the multiply and divide arithmetic, and results
// are matched in order at the rising edge. Directed corners come first, then
// random phases with varied idling on the request side.
// ---------------------------------------------------------------------------
module fixed_point_mul_div_16_16_tb;

   typedef struct packed {
      fpmd_pkg::req_type op;
      fpmd_pkg::rsp_type res;
   } owed_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   fpmd_pkg::req_type req_data = '0;
   logic              rsp_valid;
   fpmd_pkg::rsp_type rsp_data;

   fpmd_pkg::req_type op_backlog[$];
   owed_type          owed_results[$];
   logic              item_taken = 1'b0;
   int                idle_pct = 0;
   int                mismatch_cnt = 0;

   fixed_point_mul_div_16_16 u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic fpmd_pkg::rsp_type mul_div_result(fpmd_pkg::req_type op);
      fpmd_pkg::rsp_type res;
      longint  pa;
      longint  pb;
      longint  q;
      pa = $signed(op.operand_a);
      pb = $signed(op.operand_b);
      if (op.kind == fpmd_pkg::KIND_DIV && pb == 0) begin
         res.result_value = '0;
         res.status = fpmd_pkg::STATUS_DIV_ZERO;
         return res;
      end
      if (op.kind == fpmd_pkg::KIND_MUL) begin
         q = (pa * pb) >>> fpmd_pkg::FRAC_BITS;
      end else begin
         q = (pa <<< fpmd_pkg::FRAC_BITS) / pb;
      end
      res.result_value = q[31:0];
      res.status = (q[63:31] == {33{q[31]}}) ? fpmd_pkg::STATUS_OK
                                             : fpmd_pkg::STATUS_OVERFLOW;
      return res;
   endfunction

   function automatic logic [31:0] pick_operand();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 6))
         0, 1: pick_operand = r;
         2: pick_operand = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
         3: begin
            case ($urandom_range(0, 7))
               0: pick_operand = 32'h0000_0000;
               1: pick_operand = 32'h0000_0001;
               2: pick_operand = 32'hFFFF_FFFF;
               3: pick_operand = 32'h0001_0000;
               4: pick_operand = 32'hFFFF_0000;
               5: pick_operand = 32'h7FFF_FFFF;
               6: pick_operand = 32'h8000_0000;
               default: pick_operand = 32'h8000_0001;
            endcase
         end
         4: begin
            pick_operand = 32'h1 << $urandom_range(0, 31);
            if (r[0]) pick_operand = -pick_operand;
         end
         5: pick_operand = {{16{r[15]}}, r[15:0]};
         default: pick_operand = {r[31:16], 16'h0000};
      endcase
   endfunction

   task automatic queue_op(logic kind, logic [31:0] a, logic [31:0] b);
      fpmd_pkg::req_type op;
      op.kind = kind;
      op.operand_a = a;
      op.operand_b = b;
      op_backlog.push_back(op);
   endtask

   task automatic queue_random(int count);
      logic        kind;
      logic [31:0] b;
      repeat (count) begin
         kind = $urandom_range(0, 1) ? fpmd_pkg::KIND_DIV : fpmd_pkg::KIND_MUL;
         b = pick_operand();
         if (kind == fpmd_pkg::KIND_DIV && $urandom_range(0, 19) == 0) b = '0;
         queue_op(kind, pick_operand(), b);
      end
   endtask

   task automatic drain();
      while (op_backlog.size() != 0 || start || owed_results.size() != 0)
         @(posedge clock);
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !item_taken) begin
         // hold until taken
      end else if ($urandom_range(0, 99) < idle_pct || op_backlog.size() == 0) begin
         start <= 1'b0;
      end else begin
         start <= 1'b1;
         req_data <= op_backlog.pop_front();
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      owed_type got;
      item_taken <= !reset && start && !busy;
      if (!reset && start && !busy) begin
         got.op = req_data;
         got.res = mul_div_result(req_data);
         owed_results.push_back(got);
      end
      if (rsp_valid) begin
         if (owed_results.size() == 0) begin
            mismatch_cnt <= mismatch_cnt + 1;
            if (mismatch_cnt < 10)
               $display("unexpected result value=%h status=%0d",
                        rsp_data.result_value, rsp_data.status);
         end else begin
            got = owed_results.pop_front();
            if (rsp_data.result_value !== got.res.result_value ||
                rsp_data.status !== got.res.status) begin
               mismatch_cnt <= mismatch_cnt + 1;
               if (mismatch_cnt < 10)
                  $display("mismatch kind=%0d a=%h b=%h: exp %h/%0d got %h/%0d",
                           got.op.kind, got.op.operand_a, got.op.operand_b,
                           got.res.result_value, got.res.status,
                           rsp_data.result_value, rsp_data.status);
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // multiply corners
      queue_op(fpmd_pkg::KIND_MUL, 32'h0000_0000, 32'h0000_0000);
      queue_op(fpmd_pkg::KIND_MUL, 32'h0001_0000, 32'h0001_0000);
      queue_op(fpmd_pkg::KIND_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_op(fpmd_pkg::KIND_MUL, 32'h8000_0000, 32'h8000_0000);
      queue_op(fpmd_pkg::KIND_MUL, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_op(fpmd_pkg::KIND_MUL, 32'hFFFF_FFFF, 32'h0000_0001);
      queue_op(fpmd_pkg::KIND_MUL, 32'hFFFF_FFFD, 32'h0000_0005);
      queue_op(fpmd_pkg::KIND_MUL, 32'h7FFF_FFFF, 32'h0001_0000);
      queue_op(fpmd_pkg::KIND_MUL, 32'h8000_0000, 32'h0001_0000);
      queue_op(fpmd_pkg::KIND_MUL, 32'h8000_0000, 32'hFFFF_0000);
      queue_op(fpmd_pkg::KIND_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // divide corners
      queue_op(fpmd_pkg::KIND_DIV, 32'h1234_5678, 32'h0000_0000);
      queue_op(fpmd_pkg::KIND_DIV, 32'h0000_0000, 32'h0000_0000);
      queue_op(fpmd_pkg::KIND_DIV, 32'h8000_0000, 32'h0001_0000);
      queue_op(fpmd_pkg::KIND_DIV, 32'h8000_0000, 32'hFFFF_0000);
      queue_op(fpmd_pkg::KIND_DIV, 32'h0001_0000, 32'h0001_0000);
      queue_op(fpmd_pkg::KIND_DIV, 32'h7FFF_FFFF, 32'h0000_0001);
      queue_op(fpmd_pkg::KIND_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
      queue_op(fpmd_pkg::KIND_DIV, 32'hFFFF_0000, 32'h0000_0003);
      queue_op(fpmd_pkg::KIND_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_op(fpmd_pkg::KIND_DIV, 32'h0000_0001, 32'h8000_0000);
      queue_op(fpmd_pkg::KIND_DIV, 32'h8000_0000, 32'h8000_0000);
      queue_op(fpmd_pkg::KIND_DIV, 32'hFFFF_8000, 32'h0000_8000);
      drain();

      idle_pct = 0;
      queue_random(262);
      drain();
      idle_pct = 81;
      queue_random(262);
      drain();
      idle_pct = 0;
      queue_random(263);
      drain();
      idle_pct = 33;
      queue_random(263);
      drain();

      repeat (fpmd_pkg::LATENCY + 8) @(posedge clock);
      if (mismatch_cnt == 0 && owed_results.size() == 0) begin
         $display("fixed_point_mul_div_16_16_tb: clean");
      end else begin
         $display("fixed_point_mul_div_16_16_tb: errors");
      end
      $finish;
   end

   initial begin
      #2400000;
      $display("fixed_point_mul_div_16_16_tb: errors");
      $finish;
   end

endmodule
